>>> sv/phr_pkg.sv
package phr_pkg;

    // Histogram geometry.
    localparam int NUM_BINS        = 256;
    localparam int LEVEL_W         = 8;
    localparam int CMD_W           = 2;
    localparam int BIN_COUNT_W     = 17;
    localparam int COUNT_WIDTH_DEF = 17;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 8'd0;

    // Stream packing.
    localparam int S_TDATA_W = LEVEL_W;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_FIELDS_W = BIN_COUNT_W + 2 * LEVEL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;
    localparam int MIN_LSB    = BIN_COUNT_W;
    localparam int MAX_LSB    = BIN_COUNT_W + LEVEL_W;

    // Request codes carried on s_tuser.
    localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request and start the bin read
        logic commit;   // write back, update the range and load the result
    } dp_cmd_t;

endpackage

>>> sv/phr_ctrl.sv
module phr_ctrl
    import phr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The result slot can take a new result when empty or draining this cycle.
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC: begin
                cmd.commit = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

>>> sv/phr_dp.sv
module phr_dp
    import phr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    input  logic [CMD_W-1:0]       command,
    input  logic [LEVEL_W-1:0]     level,
    output logic [BIN_COUNT_W-1:0] bin_count,
    output logic [LEVEL_W-1:0]     min_level,
    output logic [LEVEL_W-1:0]     max_level,
    output logic                   is_empty
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    logic [COUNT_WIDTH-1:0] bin_mem [NUM_BINS];

    logic [NUM_BINS-1:0]    valid_reg;
    logic [NUM_BINS-1:0]    valid_next;
    logic [CMD_W-1:0]       cmd_reg;
    logic [LEVEL_W-1:0]     lvl_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   hit_reg;

    logic [LEVEL_W-1:0]     low_reg;
    logic [LEVEL_W-1:0]     low_next;
    logic [LEVEL_W-1:0]     high_reg;
    logic [LEVEL_W-1:0]     high_next;
    logic                   any_reg;
    logic                   any_next;

    logic [BIN_COUNT_W-1:0] count_out_reg;
    logic [LEVEL_W-1:0]     min_out_reg;
    logic [LEVEL_W-1:0]     max_out_reg;
    logic                   empty_out_reg;

    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic [COUNT_WIDTH-1:0] shown_count;
    logic [BIN_COUNT_W+COUNT_WIDTH-1:0] shown_wide;
    logic                   write_en;

    // A bin whose valid bit is clear has not been written since the last clear or reset.
    assign cur_count = hit_reg ? rd_data_reg : '0;
    assign inc_count = (cur_count == {COUNT_WIDTH{1'b1}}) ? cur_count : cur_count + COUNT_ONE;
    assign write_en  = cmd.commit && (cmd_reg == CMD_COUNT);

    always_comb begin
        low_next    = low_reg;
        high_next   = high_reg;
        any_next    = any_reg;
        valid_next  = valid_reg;
        shown_count = cur_count;
        case (cmd_reg)
            CMD_COUNT: begin
                shown_count         = inc_count;
                valid_next[lvl_reg] = 1'b1;
                any_next            = 1'b1;
                if (lvl_reg < low_reg) begin
                    low_next = lvl_reg;
                end
                if (lvl_reg > high_reg) begin
                    high_next = lvl_reg;
                end
            end
            CMD_CLEAR: begin
                shown_count = '0;
                valid_next  = '0;
                low_next    = LEVEL_MAX;
                high_next   = LEVEL_MIN;
                any_next    = 1'b0;
            end
            default: begin
                shown_count = cur_count;
            end
        endcase
    end

    // Zero-extend before taking the field so any counter width fits.
    assign shown_wide = {{BIN_COUNT_W{1'b0}}, shown_count};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_data_reg <= bin_mem[level];
        end
        if (write_en) begin
            bin_mem[lvl_reg] <= inc_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg <= command;
            lvl_reg <= level;
            hit_reg <= valid_reg[level];
        end
        if (cmd.commit) begin
            count_out_reg <= shown_wide[BIN_COUNT_W-1:0];
            min_out_reg   <= low_next;
            max_out_reg   <= high_next;
            empty_out_reg <= !any_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            low_reg   <= LEVEL_MAX;
            high_reg  <= LEVEL_MIN;
            any_reg   <= 1'b0;
        end else if (cmd.commit) begin
            valid_reg <= valid_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            any_reg   <= any_next;
        end
    end

    assign bin_count = count_out_reg;
    assign min_level = min_out_reg;
    assign max_level = max_out_reg;
    assign is_empty  = empty_out_reg;

endmodule

>>> sv/pixel_histogram_range_core.sv
// 256-bin histogram of 8-bit grayscale pixels with occupied-range tracking.
// Requests arrive on the s_ stream: s_tuser carries the request code (count
// pixel, read bin, clear) and s_tdata the gray level or bin index. Every
// request returns exactly one result on the m_ stream: the addressed bin's
// count after the request (zero on clear), the lowest and highest level
// counted since the last clear, and an empty flag on m_tuser.
// A request is accepted in the idle state, where the bin is read from the
// bin memory into a register; in the execute state it is written back
// together with the result, which is registered and shown on m_tvalid.
// The block takes no new request until the current one is written back;
// the bin memory's single read-modify-write per request sets that limit.
// Clear passes through the same states: per-bin valid flags are dropped
// at once, and a bin without its flag reads as zero.
// Reset (aresetn low, synchronous) empties the histogram the same way, with
// no sweep, so requests are taken right after reset.
// When the receiver stalls, the finished result waits in the output
// register; the next request is still accepted and processed up to its
// write-back, which then waits until the output register frees up.
module pixel_histogram_range_core
    import phr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] level
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] command
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [16:0] bin_count, [24:17] min_level,
                                            // [32:25] max_level, rest zero
    output logic                 m_tuser    // [0] is_empty
);

    dp_cmd_t                dp_cmd;
    logic [BIN_COUNT_W-1:0] bin_count;
    logic [LEVEL_W-1:0]     min_level;
    logic [LEVEL_W-1:0]     max_level;
    logic                   is_empty;

    // The controller sequences each request and owns both handshakes.
    phr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd)
    );

    // The datapath holds the bin memory, the range registers and the result.
    phr_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (dp_cmd),
        .command   (s_tuser),
        .level     (s_tdata),
        .bin_count (bin_count),
        .min_level (min_level),
        .max_level (max_level),
        .is_empty  (is_empty)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, max_level, min_level, bin_count};
    assign m_tuser = is_empty;

endmodule

>>> sv/phr_checker.sv
module phr_checker
    import phr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;

    assign min_level = m_tdata[MIN_LSB +: LEVEL_W];
    assign max_level = m_tdata[MAX_LSB +: LEVEL_W];

    // A stalled result holds its contents.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in progress");

    // An empty histogram reports the empty range.
    a_empty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> min_level == LEVEL_MAX && max_level == LEVEL_MIN)
        else $error("empty histogram with a nonempty range");

    // A nonempty histogram has an ordered range.
    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> min_level <= max_level)
        else $error("minimum level above maximum level");

endmodule

bind pixel_histogram_range_core phr_checker u_phr_checker (.*);
